### rtl/mdrs_pkg.sv
// Shared constants, types and helpers of the delimiter record splitter.
`timescale 1ns / 1ps
`default_nettype none

package mdrs_pkg;

    // Longest delimiter in bytes, and width of the saturating record counter
    localparam int MAX_DELIM  = 8;
    localparam int COUNT_BITS = 25;

    // Small counts (held bytes, window length, bytes per entry) run up to MAX_DELIM + 1
    localparam int CNT_W = $clog2(MAX_DELIM + 2);
    // Index of a byte inside one queue entry
    localparam int IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Register port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int LEN_REG_W = 4;
    localparam int MAXLEN_W  = 24;
    localparam int CMP_W     = (COUNT_BITS > MAXLEN_W) ? COUNT_BITS : MAXLEN_W;

    // Delimiter bytes held in the 64-bit register
    localparam int DELIM_REG_BYTES = 8;
    localparam int DELIM_SRC = (MAX_DELIM < DELIM_REG_BYTES) ? MAX_DELIM : DELIM_REG_BYTES;

    typedef enum logic [1:0] {
        REG_DELIM_LEN   = 2'd0,
        REG_DELIM_BYTES = 2'd1,
        REG_MAX_LEN     = 2'd2
    } reg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]              delim_len;
        logic [MAX_DELIM-1:0][7:0]     delim;
        logic [MAXLEN_W-1:0]           max_len;
    } cfg_t;

    // One queue entry: a run of results caused by one input word
    typedef struct packed {
        logic [MAX_DELIM-1:0][7:0]     bytes;
        logic [CNT_W-1:0]              count;
        logic                          last_at_end;
        logic                          marker;
        logic                          close;
    } entry_t;

    // Clamp the delimiter length into 1..MAX_DELIM
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_REG_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (d == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(d) > MAX_DELIM)
        begin
            r = CNT_W'(MAX_DELIM);
        end
        else
        begin
            r = CNT_W'(d);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mdrs_cfg.sv
// APB register bank of the delimiter record splitter.
`timescale 1ns / 1ps
`default_nettype none

module mdrs_cfg
    import mdrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LEN_REG_W-1:0] delim_len_reg;
    logic [DATA_W-1:0]    delim_bytes_reg;
    logic [MAXLEN_W-1:0]  max_len_reg;
    reg_idx_t             reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= LEN_REG_W'(1);
            delim_bytes_reg <= DATA_W'(10);
            max_len_reg     <= MAXLEN_W'(1000000);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DELIM_LEN:   delim_len_reg   <= pwdata[LEN_REG_W-1:0];
                REG_DELIM_BYTES: delim_bytes_reg <= pwdata;
                REG_MAX_LEN:     max_len_reg     <= pwdata[MAXLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DELIM_LEN:   prdata = DATA_W'(delim_len_reg);
            REG_DELIM_BYTES: prdata = delim_bytes_reg;
            REG_MAX_LEN:     prdata = DATA_W'(max_len_reg);
            default:         prdata = '0;
        endcase
    end

    // Bytes past the register width compare as zero
    always_comb
    begin
        cfg.delim = '0;
        for (int i = 0; i < DELIM_SRC; i++)
        begin
            cfg.delim[i] = delim_bytes_reg[8*i +: 8];
        end
        cfg.delim_len = eff_len(delim_len_reg);
        cfg.max_len   = max_len_reg;
    end

endmodule

`default_nettype wire

### rtl/mdrs_front.sv
// Front end: accepts input words, matches the delimiter window and queues results.
`timescale 1ns / 1ps
`default_nettype none

module mdrs_front
    import mdrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       op,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_entry
);

    logic [MAX_DELIM-1:0][7:0] held_reg, held_next;
    logic [CNT_W-1:0]          held_cnt_reg, held_cnt_next;
    logic                      done_reg, done_next;

    logic [MAX_DELIM:0][7:0]   win;
    logic [MAX_DELIM-1:0][7:0] shifted;
    logic [MAX_DELIM-1:0]      match_vec;
    logic [CNT_W-1:0]          dl, wl, p;
    logic                      match, accept;

    function automatic logic [7:0] pick_w(input logic [MAX_DELIM:0][7:0] w,
                                          input logic [CNT_W-1:0] idx);
        logic [7:0] r;
        r = '0;
        for (int j = 0; j <= MAX_DELIM; j++)
        begin
            if (idx == CNT_W'(j))
            begin
                r = w[j];
            end
        end
        return r;
    endfunction

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    // Window: held bytes followed by the new byte
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            win[i] = (CNT_W'(i) < held_cnt_reg) ? held_reg[i] : data_byte;
        end
        win[MAX_DELIM] = data_byte;

        dl = cfg.delim_len;
        wl = held_cnt_reg + CNT_W'(1);
        p  = wl - dl;

        for (int i = 0; i < MAX_DELIM; i++)
        begin
            match_vec[i] = (CNT_W'(i) >= dl) ||
                           (pick_w(win, p + CNT_W'(i)) == cfg.delim[i]);
            shifted[i]   = pick_w(win, p + CNT_W'(i));
        end
        match = (wl >= dl) && (&match_vec);
    end

    always_comb
    begin
        held_next              = held_reg;
        held_cnt_next          = held_cnt_reg;
        done_next              = done_reg;
        push                   = 1'b0;
        push_entry.bytes       = held_reg;
        push_entry.count       = p;
        push_entry.last_at_end = 1'b0;
        push_entry.marker      = 1'b0;
        push_entry.close       = 1'b0;

        if (accept && !done_reg)
        begin
            priority if (op)
            begin
                // End of input: flush what is held, then stop
                push                   = (held_cnt_reg != '0);
                push_entry.count       = held_cnt_reg;
                push_entry.last_at_end = 1'b1;
                push_entry.close       = 1'b1;
                held_cnt_next          = '0;
                done_next              = 1'b1;
            end
            else if (match)
            begin
                push             = 1'b1;
                push_entry.close = 1'b1;
                if (p == '0)
                begin
                    push_entry.marker = 1'b1;
                    push_entry.count  = CNT_W'(1);
                end
                else
                begin
                    push_entry.last_at_end = 1'b1;
                end
                held_cnt_next = '0;
            end
            else if (wl > dl)
            begin
                push          = 1'b1;
                held_next     = shifted;
                held_cnt_next = dl;
            end
            else
            begin
                held_next     = win[MAX_DELIM-1:0];
                held_cnt_next = wl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= CNT_W'(MAX_DELIM))
        else $error("held byte count beyond window");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("done flag cleared");

    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !push)
        else $error("result queued after end of input");

endmodule

`default_nettype wire

### rtl/mdrs_fifo.sv
// Short queue of result runs between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mdrs_fifo
    import mdrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output entry_t head
);

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

### rtl/mdrs_back.sv
// Back end: unrolls queued runs, one word per unstalled cycle; counts record length.
`timescale 1ns / 1ps
`default_nettype none

module mdrs_back
    import mdrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  entry_t     head,
    output logic       pop,
    output logic       rec_valid,
    input  logic       rec_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic       overflow
);

    logic [COUNT_BITS-1:0] rc_reg, rc_next, rc_inc;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  bv_reg, bv_next;
    logic                  last_reg, last_next;
    logic                  ovf_reg, ovf_next;
    logic                  load, fire, is_final;
    logic [CMP_W-1:0]      max_ext;

    assign load     = !valid_reg || rec_ready;
    assign fire     = load && q_valid;
    assign is_final = (CNT_W'(idx_reg) + CNT_W'(1)) == head.count;
    assign pop      = fire && is_final;
    assign max_ext  = CMP_W'(cfg.max_len);
    assign rc_inc   = (&rc_reg) ? rc_reg : rc_reg + COUNT_BITS'(1);

    always_comb
    begin
        rc_next    = rc_reg;
        idx_next   = idx_reg;
        valid_next = load ? q_valid : valid_reg;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;

        if (fire)
        begin
            idx_next = is_final ? '0 : idx_reg + IDX_W'(1);
            if (head.marker)
            begin
                byte_next = '0;
                bv_next   = 1'b0;
                last_next = 1'b1;
                ovf_next  = CMP_W'(rc_reg) > max_ext;
                rc_next   = '0;
            end
            else
            begin
                byte_next = head.bytes[idx_reg];
                bv_next   = 1'b1;
                last_next = head.last_at_end && is_final;
                ovf_next  = CMP_W'(rc_inc) > max_ext;
                rc_next   = (head.close && is_final) ? '0 : rc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg    <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            rc_reg    <= rc_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    assign rec_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bv_reg;
    assign last       = last_reg;
    assign overflow   = ovf_reg;

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_final && head.close) |=> (rc_reg == '0) && last_reg)
        else $error("record counter not cleared at end of record");

endmodule

`default_nettype wire

### rtl/multibyte_delimiter_record_splitter.sv
// Top level of the multibyte delimiter record splitter.
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte stream into records at each occurrence of a 1 to 8 byte
// delimiter (non-overlapping, delimiter removed). Each input word is either a
// data byte (op = 0) or end of input (op = 1). Output words carry one payload
// byte with byte_valid set, or an empty-record marker with byte_valid clear;
// last marks the end of a record and overflow flags bytes beyond
// max_record_len. Payload is delayed by the delimiter length: up to
// delim_len bytes stay held in case they turn out to be the delimiter, and
// end of input flushes them as a final record, after which every further
// word is taken and dropped. Throughput is one word per cycle on each side
// while rec_ready is held: the front end matches the whole delimiter window
// in parallel, combinationally, and the back end delivers one result word per
// cycle. An input word that releases several bytes at once (end of input, or
// a shortened delimiter) keeps the back end busy byte by byte; the four-entry
// queue between the two halves absorbs that, and the input stalls only once
// the queue is full. Registers sit at byte addresses 0 (delim_len),
// 8 (delim_bytes) and 16 (max_record_len); write them only while idle.

module multibyte_delimiter_record_splitter
    import mdrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    // Input words
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              op,
    input  logic [7:0]        data_byte,

    // Result words
    output logic              rec_valid,
    input  logic              rec_ready,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              last,
    output logic              overflow
);

    cfg_t   cfg;
    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;

    // Hold configuration; clamp delimiter length for the datapath
    mdrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Match the window and decide which held bytes leave with each word
    mdrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple matching from delivery
    mdrs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    // Deliver one word per cycle through the output register while rec_ready allows
    mdrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .overflow   (overflow)
    );

endmodule

`default_nettype wire
